@@ design/mebc_pkg.sv @@
// ----------------------------------------------------------------------------
// mebc_pkg
// Shared widths and constants for the minimum-error boundary cut block.
// ----------------------------------------------------------------------------
`default_nettype none

package mebc_pkg;

    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int CNT_W    = SIDE_W + 1;
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ERR_W    = 18;
    localparam int COST_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_DIR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    function automatic logic [CNT_W-1:0] clamp_side(input logic [CFG_DAT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) r = CNT_W'(1);
        else if (v > CFG_DAT_W'(MAX_SIDE)) r = CNT_W'(MAX_SIDE);
        else r = CNT_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/mebc_sqerr.sv @@
// ----------------------------------------------------------------------------
// mebc_sqerr
// Squared RGB difference of one pixel pair.
// ----------------------------------------------------------------------------
`default_nettype none

module mebc_sqerr (
    input  wire logic [7:0]                  i_a_r,
    input  wire logic [7:0]                  i_a_g,
    input  wire logic [7:0]                  i_a_b,
    input  wire logic [7:0]                  i_b_r,
    input  wire logic [7:0]                  i_b_g,
    input  wire logic [7:0]                  i_b_b,
    output logic [mebc_pkg::ERR_W-1:0]       o_err
);
    import mebc_pkg::*;

    logic [7:0]  d_r, d_g, d_b;
    logic [15:0] s_r, s_g, s_b;

    assign d_r = (i_a_r > i_b_r) ? i_a_r - i_b_r : i_b_r - i_a_r;
    assign d_g = (i_a_g > i_b_g) ? i_a_g - i_b_g : i_b_g - i_a_g;
    assign d_b = (i_a_b > i_b_b) ? i_a_b - i_b_b : i_b_b - i_a_b;
    assign s_r = d_r * d_r;
    assign s_g = d_g * d_g;
    assign s_b = d_b * d_b;
    assign o_err = ERR_W'(s_r) + ERR_W'(s_g) + ERR_W'(s_b);

endmodule

`default_nettype wire

@@ design/mebc_cost_ram.sv @@
// ----------------------------------------------------------------------------
// mebc_cost_ram
// Path cost store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mebc_cost_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [mebc_pkg::ADDR_W-1:0]   i_waddr,
    input  wire logic [mebc_pkg::COST_W-1:0]   i_wdata,
    input  wire logic [mebc_pkg::ADDR_W-1:0]   i_raddr,
    output logic [mebc_pkg::COST_W-1:0]        o_rdata
);
    import mebc_pkg::*;

    logic [COST_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/min_error_boundary_cut.sv @@
// ----------------------------------------------------------------------------
// min_error_boundary_cut
// Minimum-error boundary cut between two overlapping RGB patches.
//
// Slave stream: one pixel pair per transaction in raster order, one per
// cycle while loading; tlast marks the final pair and starts the cut.
// Configuration writes (direction, width, height) go through the plain
// write port and are to be made only while the block is idle; the block
// itself does not enforce this. After the final pair the block drops
// tready, fills the cost table over the stored errors with one shared
// adder/comparator ((H-1)*W entries), scans the last line, then emits one
// seam position per line, last line first, each backtrack step starting
// once the master side has taken the previous position. tlast marks line
// zero. The single read port of the cost store paces the cut. The master
// stream holds its transaction while tready is low and the block waits.
// Reset restores width and height 64, vertical seam, and empties the load
// position; the cost store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module min_error_boundary_cut (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mebc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [mebc_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // first_red, first_green, first_blue, second_red, second_green, second_blue
    input  wire logic [47:0]                       s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // line_index, cut_column, zero pad
    output logic [15:0]                            m_axis_tdata,
    output logic                                   m_axis_tlast
);
    import mebc_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_SETUP, S_FILL, S_SCAN, S_BACK, S_OUT
    } t_state;

    t_state              r_state;
    logic [2:0]          r_step;
    logic                r_dir;
    logic [CNT_W-1:0]    r_cols, r_rows;
    logic [CNT_W-1:0]    r_ld_row, r_ld_col;
    logic                r_ld_we;
    logic [ADDR_W-1:0]   r_ld_addr;
    logic [ERR_W-1:0]    r_ld_err;
    logic [CNT_W-1:0]    r_w, r_h;
    logic [SIDE_W-1:0]   r_line, r_pos, r_seam;
    logic [COST_W-1:0]   r_acc, r_min, r_vl, r_vr, r_best;
    logic [SIDE_W-1:0]   r_o_line, r_o_col;
    logic                r_o_last, r_o_valid;

    logic [ERR_W-1:0]    err;
    logic [COST_W-1:0]   rd;
    logic [ADDR_W-1:0]   raddr, waddr;
    logic [COST_W-1:0]   wdata;
    logic                we;
    logic [COST_W-1:0]   cmp_b;
    logic                lt;
    logic [SIDE_W-1:0]   base_pos, rd_line, rd_pos;
    logic                has_l, has_r;
    logic                s_acc;
    logic [SIDE_W-1:0]   bt_seam;
    logic [SIDE_W-1:0]   prev_line;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {4'd0, r_o_col, r_o_line};
    assign m_axis_tlast  = r_o_last;

    mebc_sqerr u_sqerr (
        .i_a_r (s_axis_tdata[7:0]),
        .i_a_g (s_axis_tdata[15:8]),
        .i_a_b (s_axis_tdata[23:16]),
        .i_b_r (s_axis_tdata[31:24]),
        .i_b_g (s_axis_tdata[39:32]),
        .i_b_b (s_axis_tdata[47:40]),
        .o_err (err)
    );

    mebc_cost_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    // neighbour addressing around the current position
    assign base_pos  = (r_state == S_BACK) ? r_seam : r_pos;
    assign has_l     = (base_pos != '0);
    assign has_r     = ({1'b0, base_pos} + CNT_W'(1)) < r_w;
    assign prev_line = r_line - SIDE_W'(1);

    always_comb begin
        rd_line = r_line;
        rd_pos  = base_pos;
        if (r_state == S_FILL) begin
            if (r_step != 3'd0) rd_line = prev_line;
        end
        if ((r_state == S_FILL && r_step == 3'd2) || (r_state == S_BACK && r_step == 3'd1)) begin
            if (has_l) rd_pos = base_pos - SIDE_W'(1);
        end
        if ((r_state == S_FILL && r_step == 3'd3) || (r_state == S_BACK && r_step == 3'd2)) begin
            if (has_r) rd_pos = base_pos + SIDE_W'(1);
        end
    end
    assign raddr = {rd_line, rd_pos};

    // shared comparator
    assign cmp_b = (r_state == S_SCAN) ? r_best : r_min;
    assign lt    = rd < cmp_b;

    assign we    = r_ld_we || (r_state == S_FILL && r_step == 3'd5);
    assign waddr = r_ld_we ? r_ld_addr : {r_line, r_pos};
    assign wdata = r_ld_we ? COST_W'(r_ld_err) : r_acc + r_min;

    always_comb begin
        bt_seam = r_seam;
        if (has_r && r_vr == r_min) begin
            bt_seam = (r_acc == r_min) ? r_seam : r_seam + SIDE_W'(1);
        end else if (has_l && r_vl == r_min) begin
            bt_seam = r_seam - SIDE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_step    <= '0;
            r_dir     <= 1'b0;
            r_cols    <= CNT_W'(MAX_SIDE);
            r_rows    <= CNT_W'(MAX_SIDE);
            r_ld_row  <= '0;
            r_ld_col  <= '0;
            r_ld_we   <= 1'b0;
            r_seam    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_ld_we <= s_acc && (r_ld_row < r_rows) && (r_ld_col < r_cols);
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_DIR:    r_dir  <= i_cfg_wdata[0];
                    CFG_WIDTH:  r_cols <= clamp_side(i_cfg_wdata);
                    CFG_HEIGHT: r_rows <= clamp_side(i_cfg_wdata);
                    default: ;
                endcase
            end
            unique case (r_state)
                S_LOAD: begin
                    if (s_acc) begin
                        r_ld_err  <= err;
                        r_ld_addr <= r_dir ? {r_ld_col[SIDE_W-1:0], r_ld_row[SIDE_W-1:0]}
                                           : {r_ld_row[SIDE_W-1:0], r_ld_col[SIDE_W-1:0]};
                        if (s_axis_tlast) begin
                            r_ld_row <= '0;
                            r_ld_col <= '0;
                            r_w      <= r_dir ? r_rows : r_cols;
                            r_h      <= r_dir ? r_cols : r_rows;
                            r_state  <= S_SETUP;
                        end else if (r_ld_row < r_rows) begin
                            if (r_ld_col + CNT_W'(1) >= r_cols) begin
                                r_ld_col <= '0;
                                r_ld_row <= r_ld_row + CNT_W'(1);
                            end else begin
                                r_ld_col <= r_ld_col + CNT_W'(1);
                            end
                        end
                    end
                end
                S_SETUP: begin
                    r_step <= '0;
                    r_pos  <= '0;
                    if (r_h == CNT_W'(1)) begin
                        r_line  <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_line  <= SIDE_W'(1);
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_step <= (r_step == 3'd5) ? 3'd0 : r_step + 3'd1;
                    case (r_step)
                        3'd1: r_acc <= rd;
                        3'd2: r_min <= rd;
                        3'd3: if (lt) r_min <= rd;
                        3'd4: if (lt) r_min <= rd;
                        3'd5: begin
                            if ({1'b0, r_pos} + CNT_W'(1) < r_w) begin
                                r_pos <= r_pos + SIDE_W'(1);
                            end else begin
                                r_pos <= '0;
                                if ({1'b0, r_line} + CNT_W'(1) < r_h) begin
                                    r_line <= r_line + SIDE_W'(1);
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    if (r_step == 3'd0) begin
                        r_step <= 3'd1;
                    end else begin
                        r_step <= '0;
                        if (r_pos == '0 || lt) begin
                            r_best <= rd;
                            r_seam <= r_pos;
                        end
                        if ({1'b0, r_pos} + CNT_W'(1) < r_w) begin
                            r_pos <= r_pos + SIDE_W'(1);
                        end else begin
                            r_o_line  <= r_line;
                            r_o_col   <= (r_pos == '0 || lt) ? r_pos : r_seam;
                            r_o_last  <= (r_line == '0);
                            r_o_valid <= 1'b1;
                            r_state   <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_o_valid <= 1'b0;
                        r_step    <= '0;
                        if (r_o_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_line  <= r_o_line - SIDE_W'(1);
                            r_state <= S_BACK;
                        end
                    end
                end
                S_BACK: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: begin
                            r_acc <= rd;
                            r_min <= rd;
                        end
                        3'd2: begin
                            r_vl <= rd;
                            if (lt) r_min <= rd;
                        end
                        3'd3: begin
                            r_vr <= rd;
                            if (lt) r_min <= rd;
                        end
                        3'd4: begin
                            r_seam    <= bt_seam;
                            r_o_line  <= r_line;
                            r_o_col   <= bt_seam;
                            r_o_last  <= (r_line == '0);
                            r_o_valid <= 1'b1;
                            r_state   <= S_OUT;
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for min_error_boundary_cut. Loads RGB pixel pair
// regions over the slave stream, predicts the seam positions of each cut with
// an in-bench cost table and backtrack, and compares every master stream
// transaction field by field, under random idling and long back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import mebc_pkg::*;

    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [5:0] line_idx;
        logic [5:0] cut_col;
        logic       last_line;
    } seam_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = CFG_DIR;
    logic [CFG_DAT_W-1:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    min_error_boundary_cut u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    int unsigned cost_tbl [DEPTH];
    bit          written  [DEPTH];
    int unsigned ld_row, ld_col;
    bit          horiz;
    logic [6:0]  width_reg, height_reg;
    seam_t       seam_q [$];

    int snd_idle, rcv_idle, hold_cycles, errors, cycles;

    function automatic int unsigned side_of(logic [6:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    function automatic int unsigned sqd(logic [7:0] a, logic [7:0] b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic int unsigned nbr_min(int unsigned ln, int unsigned p, int unsigned w);
        int unsigned m;
        m = cost_tbl[ln * MAX_SIDE + p];
        if (p != 0 && cost_tbl[ln * MAX_SIDE + p - 1] < m) m = cost_tbl[ln * MAX_SIDE + p - 1];
        if (p + 1 < w && cost_tbl[ln * MAX_SIDE + p + 1] < m) m = cost_tbl[ln * MAX_SIDE + p + 1];
        return m;
    endfunction

    function automatic void predict_seam(int unsigned w, int unsigned h);
        int unsigned best, v, m, pos, ln;
        for (int unsigned i = 1; i < h; i++)
            for (int unsigned j = 0; j < w; j++)
                cost_tbl[i * MAX_SIDE + j] += nbr_min(i - 1, j, w);
        pos = 0;
        best = cost_tbl[(h - 1) * MAX_SIDE];
        for (int unsigned j = 1; j < w; j++) begin
            v = cost_tbl[(h - 1) * MAX_SIDE + j];
            if (v < best) begin
                best = v;
                pos = j;
            end
        end
        seam_q.push_back('{6'(h - 1), 6'(pos), h == 1});
        for (int unsigned i = h - 1; i > 0; i--) begin
            ln = i - 1;
            m = nbr_min(ln, pos, w);
            if (pos + 1 < w && cost_tbl[ln * MAX_SIDE + pos + 1] == m) pos++;
            if (pos > 0 && cost_tbl[ln * MAX_SIDE + pos - 1] == m) pos--;
            seam_q.push_back('{6'(ln), 6'(pos), ln == 0});
        end
    endfunction

    function automatic void predict_pair(logic [47:0] d, logic fin);
        int unsigned cols, rows, a;
        cols = side_of(width_reg);
        rows = side_of(height_reg);
        if (ld_row < rows && ld_col < cols) begin
            a = horiz ? ld_col * MAX_SIDE + ld_row : ld_row * MAX_SIDE + ld_col;
            cost_tbl[a] = sqd(d[7:0], d[31:24]) + sqd(d[15:8], d[39:32])
                        + sqd(d[23:16], d[47:40]);
            written[a] = 1'b1;
        end
        if (ld_row < rows) begin
            ld_col++;
            if (ld_col >= cols) begin
                ld_col = 0;
                ld_row++;
            end
        end
        if (fin) begin
            if (horiz) predict_seam(rows, cols);
            else predict_seam(cols, rows);
            ld_row = 0;
            ld_col = 0;
        end
    endfunction

    // true when every entry a cut would read has been written
    function automatic bit region_ready();
        for (int r = 0; r < side_of(height_reg); r++)
            for (int c = 0; c < side_of(width_reg); c++)
                if (!written[horiz ? c * MAX_SIDE + r : r * MAX_SIDE + c]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_pair(logic [47:0] d, logic fin);
        if ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pair(d, fin);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (seam_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_DIR:    horiz = val[0];
            CFG_WIDTH:  width_reg = val;
            CFG_HEIGHT: height_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_region(bit dir, logic [6:0] w, logic [6:0] h);
        write_reg(CFG_DIR, {6'd0, dir});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // mode 0 random, 1 small values for ties, 2 all zero, 3 all max
    function automatic logic [47:0] pixel(int mode);
        logic [47:0] d;
        case (mode)
            0: d = 48'({$urandom, $urandom});
            1: for (int k = 0; k < 6; k++) d[k*8 +: 8] = 8'($urandom_range(0, 2));
            2: d = '0;
            default: d = '1;
        endcase
        return d;
    endfunction

    // full region with optional extra pairs past the end; final on the last pair
    task automatic load_region(int mode, int extra);
        int n;
        n = side_of(width_reg) * side_of(height_reg) + extra;
        for (int k = 0; k < n; k++) send_pair(pixel(mode), k == n - 1);
    endtask

    always @(posedge i_clk) begin
        seam_t got, exp_s;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tlast};
            if (seam_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result line %0d col %0d last %0d",
                                           got.line_idx, got.cut_col, got.last_line);
            end else begin
                exp_s = seam_q.pop_front();
                if (got !== exp_s) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp line %0d col %0d last %0d, got %0d %0d %0d",
                                 exp_s.line_idx, exp_s.cut_col, exp_s.last_line,
                                 got.line_idx, got.cut_col, got.last_line);
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // reset width and direction, one row so the region stays short
    task automatic test_defaults();
        write_reg(CFG_HEIGHT, 7'd1);
        load_region(1, 0);
    endtask

    task automatic test_extremes();
        set_region(1'b0, 7'd1, 7'd1);
        load_region(3, 0);
        set_region(1'b0, 7'd1, 7'd64);
        load_region(0, 0);
        set_region(1'b1, 7'd1, 7'd64);
        load_region(1, 0);
        set_region(1'b0, 7'd0, 7'd5);
        load_region(1, 0);
        set_region(1'b1, 7'd127, 7'd1);
        load_region(0, 0);
        set_region(1'b1, 7'd3, 7'd0);
        load_region(2, 0);
    endtask

    task automatic test_final_cases();
        set_region(1'b0, 7'd4, 7'd3);
        load_region(1, 5);
        send_pair(pixel(0), 1'b1);
        send_pair(pixel(1), 1'b0);
        send_pair(pixel(0), 1'b1);
    endtask

    task automatic test_backpressure();
        set_region(1'b1, 7'd10, 7'd3);
        hold_cycles = 1500;
        load_region(1, 0);
        load_region(0, 0);
        wait_drain();
        load_region(0, 0);
    endtask

    task automatic test_random(int sidle, int ridle, int items);
        int sent, n, mode;
        snd_idle = sidle;
        rcv_idle = ridle;
        sent = 0;
        while (sent < items) begin
            set_region(1'($urandom_range(1)), 7'($urandom_range(1, 8)),
                       7'($urandom_range(1, 8)));
            mode = $urandom_range(3) == 0 ? 1 : 0;
            n = $urandom_range(9) == 0 ? $urandom_range(1, 3) : 0;
            load_region(mode, n);
            sent += side_of(width_reg) * side_of(height_reg);
            if ($urandom_range(7) == 0 && region_ready()) begin
                n = $urandom_range(0, 3);
                for (int k = 0; k <= n; k++) send_pair(pixel(mode), k == n);
                sent += n + 1;
            end
        end
    endtask

    initial begin
        ld_row = 0;
        ld_col = 0;
        horiz = 1'b0;
        width_reg = 7'd64;
        height_reg = 7'd64;
        snd_idle = 14;
        rcv_idle = 47;
        hold_cycles = 0;
        errors = 0;
        cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_extremes();
        test_final_cases();
        test_backpressure();
        test_random(14, 47, 28);
        test_random(47, 14, 28);
        test_random(0, 0, 28);
        wait_drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && seam_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
